[src/dbe_pkg.sv]
// shared types and constants for the deque / bag engine
// depends on nothing; imported by every module of the block

package dbe_pkg;

  // defaults for the top-level parameters
  localparam int CAPACITY_DEF    = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  // fixed port field widths
  localparam int PORT_VAL_W = 32;
  localparam int PORT_CNT_W = 5;

  typedef enum logic [2:0] {
    REQ_ADD_FRONT = 3'd0,
    REQ_ADD_BACK  = 3'd1,
    REQ_REM_FRONT = 3'd2,
    REQ_REM_BACK  = 3'd3,
    REQ_CONTAINS  = 3'd4,
    REQ_REM_VALUE = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SEARCH,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_FETCH_F,
    S_FETCH_B,
    S_DONE
  } state_e;

  // which ring slot the store read port looks at
  typedef enum logic [1:0] {
    RD_HEAD,
    RD_NEXT,
    RD_BACK
  } rd_sel_e;

  typedef struct packed {
    logic [2:0]                   req_type;
    logic signed [PORT_VAL_W-1:0] value;
  } dbe_req_t;

  typedef struct packed {
    logic [1:0]                   status;
    logic                         found;
    logic signed [PORT_VAL_W-1:0] front_value;
    logic signed [PORT_VAL_W-1:0] back_value;
    logic [PORT_CNT_W-1:0]        count;
  } dbe_rsp_t;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    add_front;
    logic    add_back;
    logic    rem_front;
    logic    rem_back;
    logic    err_empty;
    logic    err_full;
    logic    idx_clr;
    logic    idx_inc;
    logic    set_found;
    logic    shift_wr;
    logic    cnt_dec;
    logic    cap_front;
    rd_sel_e rd_sel;
  } dbe_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] req;
    logic       empty;
    logic       full;
    logic       last;
    logic       match;
  } dbe_stat_t;

endpackage

[src/dbe_ctrl.sv]
// controller state machine of the deque / bag engine
// depends on dbe_pkg; drives dbe_dpath through dbe_cmd_t

module dbe_ctrl import dbe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  dbe_stat_t stat_i,
  output dbe_cmd_t  cmd_o,
  output logic      busy_o,
  output logic      done_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        if ((stat_i.req == REQ_CONTAINS || stat_i.req == REQ_REM_VALUE) && !stat_i.empty) begin
          state_d = S_SEARCH;
        end else begin
          state_d = S_FETCH_F;
        end
      end
      S_SEARCH: begin
        if (stat_i.match) begin
          state_d = (stat_i.req == REQ_REM_VALUE) ? S_SHIFT_RD : S_FETCH_F;
        end else if (stat_i.last) begin
          state_d = S_FETCH_F;
        end
      end
      S_SHIFT_RD: begin
        state_d = stat_i.last ? S_FETCH_F : S_SHIFT_WR;
      end
      S_SHIFT_WR: state_d = S_SHIFT_RD;
      S_FETCH_F:  state_d = S_FETCH_B;
      S_FETCH_B:  state_d = S_DONE;
      S_DONE:     state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o        = '0;
    cmd_o.rd_sel = RD_HEAD;
    busy_o       = 1'b1;
    done_o       = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      S_EXEC: begin
        unique case (stat_i.req)
          REQ_ADD_FRONT: begin
            cmd_o.err_full  = stat_i.full;
            cmd_o.add_front = !stat_i.full;
          end
          REQ_ADD_BACK: begin
            cmd_o.err_full = stat_i.full;
            cmd_o.add_back = !stat_i.full;
          end
          REQ_REM_FRONT: begin
            cmd_o.err_empty = stat_i.empty;
            cmd_o.rem_front = !stat_i.empty;
          end
          REQ_REM_BACK: begin
            cmd_o.err_empty = stat_i.empty;
            cmd_o.rem_back  = !stat_i.empty;
          end
          REQ_CONTAINS, REQ_REM_VALUE: begin
            cmd_o.err_empty = stat_i.empty;
            cmd_o.idx_clr   = 1'b1;
            cmd_o.rd_sel    = RD_HEAD;
          end
          default: ;
        endcase
      end
      S_SEARCH: begin
        if (stat_i.match) begin
          cmd_o.set_found = 1'b1;
        end else if (!stat_i.last) begin
          cmd_o.idx_inc = 1'b1;
          cmd_o.rd_sel  = RD_NEXT;
        end
      end
      S_SHIFT_RD: begin
        cmd_o.cnt_dec = stat_i.last;
        cmd_o.rd_sel  = RD_NEXT;
      end
      S_SHIFT_WR: begin
        cmd_o.shift_wr = 1'b1;
        cmd_o.idx_inc  = 1'b1;
      end
      S_FETCH_F: cmd_o.rd_sel = RD_HEAD;
      S_FETCH_B: begin
        cmd_o.cap_front = 1'b1;
        cmd_o.rd_sel    = RD_BACK;
      end
      S_DONE:  done_o = 1'b1;
      default: ;
    endcase
  end

endmodule

[src/dbe_dpath.sv]
// datapath of the deque / bag engine: ring store, head, count, search index
// depends on dbe_pkg; controlled by dbe_ctrl through dbe_cmd_t

module dbe_dpath import dbe_pkg::*; #(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  dbe_req_t  req_i,
  input  dbe_cmd_t  cmd_i,
  output dbe_stat_t stat_o,
  output dbe_rsp_t  result_o
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = IDX_W + 1;
  localparam int XW    = (VALUE_WIDTH > PORT_VAL_W) ? VALUE_WIDTH : PORT_VAL_W;

  // ring position k places behind the front, k <= CAPACITY
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                               input logic [CNT_W-1:0] k);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(head) + SUM_W'(k);
    if (sum >= SUM_W'(CAPACITY)) sum = sum - SUM_W'(CAPACITY);
    return sum[IDX_W-1:0];
  endfunction

  logic [VALUE_WIDTH-1:0] mem [CAPACITY];

  logic [2:0]             req_q;
  logic [VALUE_WIDTH-1:0] value_q;
  logic [1:0]             status_q;
  logic                   found_q;
  logic [VALUE_WIDTH-1:0] front_q;
  logic [VALUE_WIDTH-1:0] rd_q;
  logic [IDX_W-1:0]       head_q, head_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [IDX_W-1:0]       idx_q, idx_d;

  logic [XW-1:0]          in_ext, front_ext, back_ext;
  logic [CNT_W-1:0]       idx_p1;
  logic [IDX_W-1:0]       head_dec;
  logic                   empty;
  logic [IDX_W-1:0]       rd_addr, wr_addr;
  logic [VALUE_WIDTH-1:0] wr_data;
  logic                   wr_en;

  assign in_ext   = XW'($unsigned(req_i.value));
  assign idx_p1   = CNT_W'(idx_q) + CNT_W'(1);
  assign head_dec = (head_q == '0) ? IDX_W'(CAPACITY - 1) : head_q - IDX_W'(1);
  assign empty    = (count_q == '0);

  assign stat_o.req   = req_q;
  assign stat_o.empty = empty;
  assign stat_o.full  = (count_q == CNT_W'(CAPACITY));
  assign stat_o.last  = (idx_p1 == count_q);
  assign stat_o.match = (rd_q == value_q);

  // read port address
  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_HEAD: rd_addr = head_q;
      RD_NEXT: rd_addr = slot_of(head_q, idx_p1);
      RD_BACK: rd_addr = empty ? head_q : slot_of(head_q, count_q - CNT_W'(1));
      default: rd_addr = head_q;
    endcase
  end

  // write port
  always_comb begin
    wr_en   = 1'b1;
    wr_addr = head_dec;
    wr_data = value_q;
    priority if (cmd_i.add_front) begin
      wr_addr = head_dec;
    end else if (cmd_i.add_back) begin
      wr_addr = slot_of(head_q, count_q);
    end else if (cmd_i.shift_wr) begin
      wr_addr = slot_of(head_q, CNT_W'(idx_q));
      wr_data = rd_q;
    end else begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  // ring pointers
  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    idx_d   = idx_q;
    if (cmd_i.add_front) begin
      head_d  = head_dec;
      count_d = count_q + CNT_W'(1);
    end
    if (cmd_i.add_back) count_d = count_q + CNT_W'(1);
    if (cmd_i.rem_front) begin
      head_d  = slot_of(head_q, CNT_W'(1));
      count_d = count_q - CNT_W'(1);
    end
    if (cmd_i.rem_back || cmd_i.cnt_dec) count_d = count_q - CNT_W'(1);
    if (cmd_i.idx_clr) idx_d = '0;
    if (cmd_i.idx_inc) idx_d = idx_q + IDX_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  // request and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q    <= req_i.req_type;
      value_q  <= in_ext[VALUE_WIDTH-1:0];
      status_q <= ST_OK;
      found_q  <= 1'b0;
    end
    if (cmd_i.err_empty) status_q <= ST_EMPTY;
    if (cmd_i.err_full)  status_q <= ST_FULL;
    if (cmd_i.set_found) found_q  <= 1'b1;
    if (cmd_i.cap_front) front_q  <= rd_q;
  end

  assign front_ext = XW'(front_q);
  assign back_ext  = XW'(rd_q);

  assign result_o.status      = status_q;
  assign result_o.found       = found_q;
  assign result_o.front_value = empty ? '0 : signed'(front_ext[PORT_VAL_W-1:0]);
  assign result_o.back_value  = empty ? '0 : signed'(back_ext[PORT_VAL_W-1:0]);
  assign result_o.count       = PORT_CNT_W'(count_q);

endmodule

[src/deque_bag_engine_core.sv]
// top level of the deque / bag engine: controller plus datapath
// depends on dbe_pkg, dbe_ctrl, dbe_dpath
//
//   channel   ports                     beat taken when
//   request   start, busy, req_i        rising edge with start high, busy low
//   result    done_o, result_o          rising edge ending the done_o cycle
//
// sequence: end operations (add, remove, unknown codes) pass through exec,
//   fetch front, fetch back and done; contains and remove value first walk the
//   entries in search; on a match remove value then closes the gap behind it,
//   a shift read and a shift write per entry
// the pace is set by the single-read-port ring store: one entry per cycle
//   for search, a read and a write per entry when closing the gap
// reset clears head, count and controller; the store needs no clearing
// the receiver cannot stall: a result shows for exactly one cycle, after
//   which busy drops and the next request may be taken

module deque_bag_engine_core import dbe_pkg::*; #(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  dbe_req_t req_i,
  output logic     done_o,
  output dbe_rsp_t result_o
);

  dbe_cmd_t  cmd;
  dbe_stat_t stat;

  // sequencing of each request
  dbe_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy),
    .done_o (done_o)
  );

  // ring store, pointers and result registers
  dbe_dpath #(
    .CAPACITY   (CAPACITY),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dpath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .cmd_i   (cmd),
    .stat_o  (stat),
    .result_o(result_o)
  );

endmodule

[src/dbe_checker.sv]
// port-level checks for deque_bag_engine_core, bound to the top level
// depends on dbe_pkg

module dbe_checker import dbe_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input logic     busy,
  input logic     done_o,
  input dbe_rsp_t result_o
);

  // a result only appears while a request is in flight
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result beat without busy");

  // the engine is free again right after a result
  a_done_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy)
    else $error("busy held after result beat");

  // an accepted request never answers in the next cycle
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_o))
    else $error("request not taken in properly");

  // errors never report a match
  a_err_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status != ST_OK) |-> !result_o.found)
    else $error("found set on error result");

  // an empty error means an empty store
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status == ST_EMPTY) |->
      (result_o.count == '0 && result_o.front_value == '0 && result_o.back_value == '0))
    else $error("empty error with entries present");

endmodule

bind deque_bag_engine_core dbe_checker u_dbe_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start   (start),
  .busy    (busy),
  .done_o  (done_o),
  .result_o(result_o)
);

[bench/tb_top.sv]
`timescale 1ns / 100ps
// self-checking bench for deque_bag_engine_core: a shadow deque predicts each result beat
// depends on dbe_pkg and the deque_bag_engine_core rtl; needs no files or arguments

module tb_top import dbe_pkg::*; ();

  localparam int CAP = CAPACITY_DEF;

  // codes the block must treat as no-ops
  localparam logic [2:0] REQ_SPARE_A = 3'd6;
  localparam logic [2:0] REQ_SPARE_B = 3'd7;

  // shadow copy of the ring store; every accepted request is applied here and
  // the response it should produce is queued until the matching result beat
  class deque_shadow;
    logic [PORT_VAL_W-1:0] ring [CAP];
    int unsigned           head;
    int unsigned           fill;
    dbe_rsp_t              answers_due [$];
    int unsigned           mismatches;

    function new();
      head       = 0;
      fill       = 0;
      mismatches = 0;
    endfunction

    // ring position k places behind the front
    function int unsigned slot(int unsigned k);
      return (head + k) % CAP;
    endfunction

    function logic [PORT_VAL_W-1:0] any_stored();
      return ring[slot($urandom_range(fill - 1))];
    endfunction

    function int unsigned pending();
      return answers_due.size();
    endfunction

    function void apply_request(dbe_req_t r);
      dbe_rsp_t    ans;
      int unsigned k;
      bit          hit;
      ans = '0;
      hit = 1'b0;
      case (r.req_type)
        REQ_ADD_FRONT, REQ_ADD_BACK: begin
          if (fill >= CAP) begin
            ans.status = ST_FULL;
          end else if (r.req_type == REQ_ADD_FRONT) begin
            head       = (head == 0) ? CAP - 1 : head - 1;
            ring[head] = r.value;
            fill++;
          end else begin
            ring[slot(fill)] = r.value;
            fill++;
          end
        end
        REQ_REM_FRONT, REQ_REM_BACK: begin
          if (fill == 0) begin
            ans.status = ST_EMPTY;
          end else begin
            if (r.req_type == REQ_REM_FRONT) head = slot(1);
            fill--;
          end
        end
        REQ_CONTAINS, REQ_REM_VALUE: begin
          if (fill == 0) begin
            ans.status = ST_EMPTY;
          end else begin
            k = 0;
            while (k < fill && !hit) begin
              if (ring[slot(k)] == r.value) hit = 1'b1;
              else k++;
            end
            // close the gap behind the first match, order kept
            if (hit && r.req_type == REQ_REM_VALUE) begin
              while (k + 1 < fill) begin
                ring[slot(k)] = ring[slot(k + 1)];
                k++;
              end
              fill--;
            end
          end
        end
        default: begin
        end
      endcase
      ans.found       = hit;
      ans.front_value = (fill != 0) ? ring[slot(0)] : '0;
      ans.back_value  = (fill != 0) ? ring[slot(fill - 1)] : '0;
      ans.count       = PORT_CNT_W'(fill);
      answers_due.push_back(ans);
    endfunction

    task note_mismatch(string what);
      if (mismatches < 40) $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    task compare_response(dbe_rsp_t got);
      dbe_rsp_t want;
      if (answers_due.size() == 0) begin
        note_mismatch("result beat with no request outstanding");
        return;
      end
      want = answers_due.pop_front();
      if (got.status !== want.status)
        note_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.found !== want.found)
        note_mismatch($sformatf("found got %0b want %0b", got.found, want.found));
      if (got.front_value !== want.front_value)
        note_mismatch($sformatf("front_value got %h want %h", got.front_value,
                                want.front_value));
      if (got.back_value !== want.back_value)
        note_mismatch($sformatf("back_value got %h want %h", got.back_value,
                                want.back_value));
      if (got.count !== want.count)
        note_mismatch($sformatf("count got %0d want %0d", got.count, want.count));
    endtask
  endclass

  logic     clk_i  = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start  = 1'b0;
  dbe_req_t req_i  = '0;
  logic     busy;
  logic     done_o;
  dbe_rsp_t result_o;

  deque_shadow shadow;

  // sender idle chance per cycle, in percent
  int unsigned idle_pct = 0;
  // drift direction of the random part: toward full or toward empty
  bit filling = 1'b1;

  logic [PORT_VAL_W-1:0] corners [6] = '{32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
                                         32'h0000_0000, 32'h5555_5555, 32'haaaa_aaaa};
  // small per-phase pool so that duplicates land in the store
  logic [PORT_VAL_W-1:0] pool [6];

  deque_bag_engine_core #(
    .CAPACITY   (CAP),
    .VALUE_WIDTH(VALUE_WIDTH_DEF)
  ) uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .req_i   (req_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // result beats show for one cycle only, so every strobe is checked
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) shadow.compare_response(result_o);
  end

  // hold start until a beat is taken, then maybe idle with junk on req_i
  task automatic send_req(input dbe_req_t item);
    dbe_req_t junk;
    start <= 1'b1;
    req_i <= item;
    do @(posedge clk_i); while (busy !== 1'b0);
    shadow.apply_request(item);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do begin
        junk.req_type = 3'($urandom_range(7));
        junk.value    = $urandom;
        req_i <= junk;
        @(posedge clk_i);
      end while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic send_op(input logic [2:0] kind, input logic [PORT_VAL_W-1:0] v);
    dbe_req_t item;
    item.req_type = kind;
    item.value    = v;
    send_req(item);
  endtask

  // searches mostly aim at something stored so that hits are common
  function automatic logic [PORT_VAL_W-1:0] pick_value(input bit search);
    int unsigned sel;
    if (search && shadow.fill != 0 && $urandom_range(99) < 60) return shadow.any_stored();
    sel = $urandom_range(9);
    if (sel < 2) return $urandom;
    if (sel == 2) return corners[$urandom_range(5)];
    return pool[$urandom_range(5)];
  endfunction

  function automatic dbe_req_t make_item();
    dbe_req_t    item;
    int unsigned roll;
    int unsigned add_lim;
    int unsigned end_lim;
    int unsigned look_lim;
    // swing the fill level between empty and full
    if (shadow.fill == CAP) filling = 1'b0;
    else if (shadow.fill == 0) filling = 1'b1;
    add_lim  = filling ? 55 : 20;
    end_lim  = filling ? 70 : 55;
    look_lim = filling ? 85 : 70;
    roll     = $urandom_range(99);
    if (roll < add_lim) begin
      item.req_type = $urandom_range(1) ? REQ_ADD_BACK : REQ_ADD_FRONT;
      item.value    = pick_value(1'b0);
    end else if (roll < end_lim) begin
      item.req_type = $urandom_range(1) ? REQ_REM_BACK : REQ_REM_FRONT;
      item.value    = $urandom;
    end else if (roll < look_lim) begin
      item.req_type = REQ_CONTAINS;
      item.value    = pick_value(1'b1);
    end else if (roll < 97) begin
      item.req_type = REQ_REM_VALUE;
      item.value    = pick_value(1'b1);
    end else begin
      item.req_type = $urandom_range(1) ? REQ_SPARE_B : REQ_SPARE_A;
      item.value    = $urandom;
    end
    return item;
  endfunction

  // idle levels per phase; the receiver can't hold results off, so the
  // receiver-stall phase runs flat out and the mixed phase keeps its sender part
  int unsigned idle_levels [4] = '{0, 73, 0, 29};

  initial begin
    shadow = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty store errors and an unused code
    send_op(REQ_REM_FRONT, 32'h0);
    send_op(REQ_REM_BACK, 32'h0);
    send_op(REQ_CONTAINS, 32'h0);
    send_op(REQ_REM_VALUE, 32'h0);
    send_op(REQ_SPARE_A, 32'hffff_ffff);

    // fill from both ends so the head wraps, corner values first
    for (int i = 0; i < CAP; i++) begin
      send_op((i % 2 != 0) ? REQ_ADD_BACK : REQ_ADD_FRONT,
              (i < 6) ? corners[i] : i * 32'h0101_0101);
    end
    send_op(REQ_ADD_BACK, 32'h1);              // full store
    send_op(REQ_CONTAINS, 32'h8000_0000);      // hit
    send_op(REQ_REM_VALUE, 32'h5555_5555);     // match mid-store, gap closed
    send_op(REQ_REM_VALUE, 32'h1234_5678);     // no match

    for (int p = 0; p < 4; p++) begin
      idle_pct = idle_levels[p];
      foreach (pool[j]) pool[j] = $urandom;
      repeat (350) send_req(make_item());
    end

    start <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk_i);
    // room for a stray beat after the last one owed
    repeat (60) @(posedge clk_i);

    if (shadow.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // hard stop, far above the slowest legal run
  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
